[rtl/spo_pkg.sv]
// shared types, widths and helpers for the shape pair overlap test
`default_nettype none

package spo_pkg;

    // field widths, all following from the coordinate width
    localparam int COORD_BITS = 16;
    localparam int CW  = COORD_BITS;      // center coordinate width
    localparam int SZW = COORD_BITS - 1;  // full box size width
    localparam int RAW = COORD_BITS - 2;  // radius field width
    localparam int DW  = COORD_BITS + 3;  // signed delta width (doubled values)
    localparam int MW  = COORD_BITS + 2;  // delta magnitude width
    localparam int RW  = COORD_BITS;      // doubled radius (or radius sum) width
    localparam int SQW = 2 * MW;          // squared delta width
    localparam int RSW = 2 * RW;          // squared radius width
    localparam int SW  = SQW + 1;         // sum of two squares width

    // pair kinds
    typedef enum logic [1:0] {
        KIND_CC  = 2'd0,
        KIND_CB  = 2'd1,
        KIND_BB  = 2'd2,
        KIND_RSV = 2'd3
    } kind_t;

    // stage 1 to stage 2: deltas and radius
    typedef struct packed {
        logic                 valid;
        kind_t                kind;
        logic signed [DW-1:0] dcx;
        logic signed [DW-1:0] dcy;
        logic [CW-1:0]        sumw;
        logic [CW-1:0]        sumh;
        logic signed [DW-1:0] dxa;
        logic signed [DW-1:0] dxb;
        logic signed [DW-1:0] dya;
        logic signed [DW-1:0] dyb;
        logic [RW-1:0]        rad;
    } s1_t;

    // stage 2 to stage 3: squares and early flags
    typedef struct packed {
        logic           valid;
        kind_t          kind;
        logic           box_hit;
        logic           edge_hit;
        logic [SQW-1:0] sq0;
        logic [SQW-1:0] sq1;
        logic [SQW-1:0] sq2;
        logic [SQW-1:0] sq3;
        logic [RSW-1:0] rsq;
    } s2_t;

    // magnitude of a signed delta
    function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] v);
        logic [DW-1:0] a;
        a = v[DW-1] ? DW'(-v) : DW'(v);
        return a[MW-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/spo_prep.sv]
// stage 1: doubled coordinates, edge deltas and radius selection
`default_nettype none

module spo_prep (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [1:0]                         opcode,
    input  logic signed [spo_pkg::CW-1:0]      a_x,
    input  logic signed [spo_pkg::CW-1:0]      a_y,
    input  logic [spo_pkg::SZW-1:0]            a_w,
    input  logic [spo_pkg::SZW-1:0]            a_h,
    input  logic [spo_pkg::RAW-1:0]            a_r,
    input  logic signed [spo_pkg::CW-1:0]      b_x,
    input  logic signed [spo_pkg::CW-1:0]      b_y,
    input  logic [spo_pkg::SZW-1:0]            b_w,
    input  logic [spo_pkg::SZW-1:0]            b_h,
    input  logic [spo_pkg::RAW-1:0]            b_r,
    output spo_pkg::s1_t                       s1
);
    import spo_pkg::*;

    logic signed [DW-1:0] ax2;
    logic signed [DW-1:0] ay2;
    logic signed [DW-1:0] bx2;
    logic signed [DW-1:0] by2;
    logic signed [DW-1:0] bw_e;
    logic signed [DW-1:0] bh_e;
    logic [RW-1:0]        ar2;
    logic [RW-1:0]        br2;
    s1_t                  s1_reg;
    s1_t                  s1_next;

    // doubled centers, sizes as they stand (half sizes of doubled boxes)
    assign ax2  = {{(DW-CW-1){a_x[CW-1]}}, a_x, 1'b0};
    assign ay2  = {{(DW-CW-1){a_y[CW-1]}}, a_y, 1'b0};
    assign bx2  = {{(DW-CW-1){b_x[CW-1]}}, b_x, 1'b0};
    assign by2  = {{(DW-CW-1){b_y[CW-1]}}, b_y, 1'b0};
    assign bw_e = {{(DW-SZW){1'b0}}, b_w};
    assign bh_e = {{(DW-SZW){1'b0}}, b_h};
    assign ar2  = {{(RW-RAW-1){1'b0}}, a_r, 1'b0};
    assign br2  = {{(RW-RAW-1){1'b0}}, b_r, 1'b0};

    // deltas from circle center to box edges, center distances, size sums, radius
    always_comb
    begin
        s1_next.valid = in_valid;
        s1_next.kind  = kind_t'(opcode);
        s1_next.dcx   = ax2 - bx2;
        s1_next.dcy   = ay2 - by2;
        s1_next.sumw  = CW'(a_w) + CW'(b_w);
        s1_next.sumh  = CW'(a_h) + CW'(b_h);
        s1_next.dxa   = bx2 - ax2 - bw_e;
        s1_next.dxb   = bx2 - ax2 + bw_e;
        s1_next.dya   = by2 - ay2 - bh_e;
        s1_next.dyb   = by2 - ay2 + bh_e;
        s1_next.rad   = (kind_t'(opcode) == KIND_CC) ? (ar2 + br2) : ar2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

`default_nettype wire

[rtl/spo_square.sv]
// stage 2: squares of deltas and radius, box and widened-box compares
`default_nettype none

module spo_square (
    input  logic         clk,
    input  logic         rst_n,
    input  spo_pkg::s1_t s1,
    output spo_pkg::s2_t s2
);
    import spo_pkg::*;

    logic signed [DW-1:0] rad_s;
    logic signed [DW-1:0] sw_s;
    logic signed [DW-1:0] sh_s;
    logic [MW-1:0]        m0;
    logic [MW-1:0]        m1;
    logic [MW-1:0]        m2;
    logic [MW-1:0]        m3;
    logic                 wide_x;
    logic                 wide_y;
    s2_t                  s2_reg;
    s2_t                  s2_next;

    assign rad_s = {{(DW-RW){1'b0}}, s1.rad};
    assign sw_s  = {{(DW-CW){1'b0}}, s1.sumw};
    assign sh_s  = {{(DW-CW){1'b0}}, s1.sumh};

    // multiplier operands: circle pairs reuse the first corner lane
    assign m0 = (s1.kind == KIND_CC) ? mag(s1.dcx) : mag(s1.dxa);
    assign m1 = mag(s1.dxb);
    assign m2 = (s1.kind == KIND_CC) ? mag(s1.dcy) : mag(s1.dya);
    assign m3 = mag(s1.dyb);

    // center strictly inside the box widened on x only or on y only
    assign wide_x = (s1.dxa < rad_s) && ((s1.dxb + rad_s) > 0) &&
                    (s1.dya < 0) && (s1.dyb > 0);
    assign wide_y = (s1.dxa < 0) && (s1.dxb > 0) &&
                    (s1.dya < rad_s) && ((s1.dyb + rad_s) > 0);

    always_comb
    begin
        s2_next.valid    = s1.valid;
        s2_next.kind     = s1.kind;
        s2_next.box_hit  = (s1.dcx <= sw_s) && (-s1.dcx <= sw_s) &&
                           (s1.dcy <= sh_s) && (-s1.dcy <= sh_s);
        s2_next.edge_hit = wide_x || wide_y;
        s2_next.sq0      = SQW'(m0) * SQW'(m0);
        s2_next.sq1      = SQW'(m1) * SQW'(m1);
        s2_next.sq2      = SQW'(m2) * SQW'(m2);
        s2_next.sq3      = SQW'(m3) * SQW'(m3);
        s2_next.rsq      = RSW'(s1.rad) * RSW'(s1.rad);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

`default_nettype wire

[rtl/spo_decide.sv]
// stage 3: corner distance compares and final hit selection
`default_nettype none

module spo_decide (
    input  logic         clk,
    input  logic         rst_n,
    input  spo_pkg::s2_t s2,
    output logic         done,
    output logic         hit
);
    import spo_pkg::*;

    logic [SW-1:0] rsq_e;
    logic          c0;
    logic          c1;
    logic          c2;
    logic          c3;
    logic          res;
    logic          done_reg;
    logic          done_next;
    logic          hit_reg;
    logic          hit_next;

    assign rsq_e = SW'(s2.rsq);

    // squared distance to each corner strictly below squared radius
    assign c0 = (SW'(s2.sq0) + SW'(s2.sq2)) < rsq_e;
    assign c1 = (SW'(s2.sq1) + SW'(s2.sq2)) < rsq_e;
    assign c2 = (SW'(s2.sq0) + SW'(s2.sq3)) < rsq_e;
    assign c3 = (SW'(s2.sq1) + SW'(s2.sq3)) < rsq_e;

    // result per pair kind
    always_comb
    begin
        unique case (s2.kind)
            KIND_CC:  res = c0;
            KIND_CB:  res = s2.edge_hit || c0 || c1 || c2 || c3;
            KIND_BB:  res = s2.box_hit;
            KIND_RSV: res = 1'b0;
            default:  res = 1'b0;
        endcase
    end

    assign done_next = s2.valid;
    assign hit_next  = s2.valid && res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            hit_reg  <= hit_next;
        end
    end

    assign done = done_reg;
    assign hit  = hit_reg;

endmodule

`default_nettype wire

[rtl/shape_pair_overlap_test.sv]
// top level of the shape pair overlap test pipeline
//
// usage:
//   an item (pair kind plus centers, sizes and radii of shapes a and b) is
//   taken at a rising edge with start high and busy low. busy is always low,
//   so one item can be taken every cycle.
//   each item returns one hit flag on hit, marked by a one-cycle done strobe;
//   results leave in order.
//   throughput: one item per cycle. there are three register stages
//   (edge deltas, squaring multipliers, corner compares).
//   pair kinds: circle-circle, circle a against box b, box-box; the reserved
//   kind returns hit low. values are q12.4 and are doubled internally so box
//   half sizes are exact; all products are exact.
//   the receiver cannot hold results off and nothing in the block waits on it.
//   reset clears all stage valid bits; items in flight are dropped and no
//   done strobe follows until a new item is taken.
`default_nettype none

module shape_pair_overlap_test (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic signed [spo_pkg::CW-1:0] a_x,
    input  logic signed [spo_pkg::CW-1:0] a_y,
    input  logic [spo_pkg::SZW-1:0]       a_w,
    input  logic [spo_pkg::SZW-1:0]       a_h,
    input  logic [spo_pkg::RAW-1:0]       a_r,
    input  logic signed [spo_pkg::CW-1:0] b_x,
    input  logic signed [spo_pkg::CW-1:0] b_y,
    input  logic [spo_pkg::SZW-1:0]       b_w,
    input  logic [spo_pkg::SZW-1:0]       b_h,
    input  logic [spo_pkg::RAW-1:0]       b_r,
    output logic                          done,
    output logic                          hit
);
    import spo_pkg::*;

    s1_t  s1;
    s2_t  s2;
    logic take;

    // fully pipelined, never holds off an item
    assign busy = 1'b0;
    assign take = start && !busy;

    spo_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (take),
        .opcode   (opcode),
        .a_x      (a_x),
        .a_y      (a_y),
        .a_w      (a_w),
        .a_h      (a_h),
        .a_r      (a_r),
        .b_x      (b_x),
        .b_y      (b_y),
        .b_w      (b_w),
        .b_h      (b_h),
        .b_r      (b_r),
        .s1       (s1)
    );

    spo_square u_square (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .s2    (s2)
    );

    spo_decide u_decide (
        .clk   (clk),
        .rst_n (rst_n),
        .s2    (s2),
        .done  (done),
        .hit   (hit)
    );

endmodule

`default_nettype wire

[rtl/spo_checker.sv]
// port-level checker for the shape pair overlap test, with its bind
`default_nettype none

module spo_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] opcode,
    input logic       done,
    input logic       hit
);
    import spo_pkg::*;

    // every taken item is followed by its done strobe
    a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##2 done)
        else $error("item taken without a done strobe three cycles later");

    // no strobe without a matching taken item
    a_done_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start, 3) && !$past(busy, 3)))
        else $error("done strobe without a matching item");

    // hit only shows together with its strobe
    a_hit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done)
        else $error("hit high outside a done strobe");

    // reserved pair kind never reports a hit
    a_rsv_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == KIND_RSV)) |=> ##2 !hit)
        else $error("reserved pair kind reported a hit");

endmodule

bind shape_pair_overlap_test spo_checker u_spo_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .opcode (opcode),
    .done   (done),
    .hit    (hit)
);

`default_nettype wire

[bench/tb_shape_pair_overlap_test.sv]
// self-checking testbench for the shape pair overlap test pipeline
`default_nettype none

module tb_shape_pair_overlap_test;
    import spo_pkg::*;

    localparam int STALL_LIMIT = 1000;  // cycles with no item and no result taken
    localparam int RANDOM_PAIRS = 550;

    // one shape pair as it appears on the ports
    typedef struct {
        kind_t                kind;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic [SZW-1:0]       aw;
        logic [SZW-1:0]       ah;
        logic [RAW-1:0]       ar;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic [SZW-1:0]       bw;
        logic [SZW-1:0]       bh;
        logic [RAW-1:0]       br;
    } pair_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           opcode = KIND_CC;
    logic signed [CW-1:0] a_x = '0;
    logic signed [CW-1:0] a_y = '0;
    logic [SZW-1:0]       a_w = '0;
    logic [SZW-1:0]       a_h = '0;
    logic [RAW-1:0]       a_r = '0;
    logic signed [CW-1:0] b_x = '0;
    logic signed [CW-1:0] b_y = '0;
    logic [SZW-1:0]       b_w = '0;
    logic [SZW-1:0]       b_h = '0;
    logic [RAW-1:0]       b_r = '0;
    logic                 done;
    logic                 hit;

    pair_t pending_pairs[$];
    bit    expected_hits[$];
    bit    item_taken = 1'b0;
    int    gap_left = 0;
    int    burst_left = 0;
    int    stall_cycles = 0;
    int    mismatches = 0;

    shape_pair_overlap_test i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .opcode (opcode),
        .a_x    (a_x),
        .a_y    (a_y),
        .a_w    (a_w),
        .a_h    (a_h),
        .a_r    (a_r),
        .b_x    (b_x),
        .b_y    (b_y),
        .b_w    (b_w),
        .b_h    (b_h),
        .b_r    (b_r),
        .done   (done),
        .hit    (hit)
    );

    // 20 unit clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // squared distance strictly below squared radius, exact in 64 bits
    function automatic bit within_radius(input longint dx, input longint dy, input longint r);
        return dx * dx + dy * dy < r * r;
    endfunction

    // circle against box, all values doubled
    function automatic bit circle_meets_box(input longint cx, input longint cy, input longint r,
                                            input longint x1, input longint x2,
                                            input longint y1, input longint y2);
        if (x1 - r < cx && cx < x2 + r && y1 < cy && cy < y2)
            return 1'b1;
        if (x1 < cx && cx < x2 && y1 - r < cy && cy < y2 + r)
            return 1'b1;
        return within_radius(x1 - cx, y1 - cy, r) || within_radius(x2 - cx, y1 - cy, r) ||
               within_radius(x1 - cx, y2 - cy, r) || within_radius(x2 - cx, y2 - cy, r);
    endfunction

    // expected hit flag for one pair
    function automatic bit pair_overlaps(input pair_t p);
        longint ax = 2 * longint'(p.ax);
        longint ay = 2 * longint'(p.ay);
        longint aw = longint'(p.aw);
        longint ah = longint'(p.ah);
        longint ar = 2 * longint'(p.ar);
        longint bx = 2 * longint'(p.bx);
        longint by = 2 * longint'(p.by);
        longint bw = longint'(p.bw);
        longint bh = longint'(p.bh);
        longint br = 2 * longint'(p.br);
        case (p.kind)
            KIND_CC: return within_radius(ax - bx, ay - by, ar + br);
            KIND_CB: return circle_meets_box(ax, ay, ar, bx - bw, bx + bw, by - bh, by + bh);
            KIND_BB: return (bx - bw) <= (ax + aw) && (bx + bw) >= (ax - aw) &&
                            (by - bh) <= (ay + ah) && (by + bh) >= (ay - ah);
            default: return 1'b0;
        endcase
    endfunction

    function automatic pair_t make_pair(input kind_t kind,
                                        input int ax, input int ay, input int aw, input int ah,
                                        input int ar, input int bx, input int by,
                                        input int bw, input int bh, input int br);
        pair_t p;
        p.kind = kind;
        p.ax = CW'(ax);
        p.ay = CW'(ay);
        p.aw = SZW'(aw);
        p.ah = SZW'(ah);
        p.ar = RAW'(ar);
        p.bx = CW'(bx);
        p.by = CW'(by);
        p.bw = SZW'(bw);
        p.bh = SZW'(bh);
        p.br = RAW'(br);
        return p;
    endfunction

    // random pair: mostly shapes near each other on a random scale, some fully random
    function automatic pair_t random_pair();
        pair_t p;
        int    style;
        int    span;
        int    off;
        p = make_pair(kind_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        style = $urandom_range(0, 9);
        if (style >= 3)
        begin
            span = 1 << $urandom_range(2, 13);
            off = int'($urandom_range(0, 2 * span)) - span;
            p.bx = CW'(int'(p.ax) + off);
            off = int'($urandom_range(0, 2 * span)) - span;
            p.by = CW'(int'(p.ay) + off);
            p.aw = SZW'($urandom_range(0, span));
            p.ah = SZW'($urandom_range(0, span));
            p.bw = SZW'($urandom_range(0, span));
            p.bh = SZW'($urandom_range(0, span));
            p.ar = RAW'($urandom_range(0, span));
            p.br = RAW'($urandom_range(0, span));
            // edges and circles just touching, give or take one lsb
            if (style == 9)
            begin
                off = int'($urandom_range(0, 2)) - 1;
                p.bw = p.aw;
                p.by = p.ay;
                if (p.kind == KIND_CC)
                    p.bx = CW'(int'(p.ax) + int'(p.ar) + int'(p.br) + off);
                else
                    p.bx = CW'(int'(p.ax) + int'(p.aw) + off);
            end
        end
        return p;
    endfunction

    // idle gap after an item: mostly none or short, a few long, sometimes a burst with none
    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_left != 0)
        begin
            burst_left--;
            return 0;
        end
        if (roll < 4)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // driver: present the next item or idle at each falling edge
    always @(negedge clk)
    begin : driver
        pair_t p;
        if (rst_n && (!start || item_taken))
        begin
            if (gap_left != 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_pairs.size() != 0)
            begin
                p = pending_pairs.pop_front();
                opcode <= p.kind;
                a_x <= p.ax;
                a_y <= p.ay;
                a_w <= p.aw;
                a_h <= p.ah;
                a_r <= p.ar;
                b_x <= p.bx;
                b_y <= p.by;
                b_w <= p.bw;
                b_h <= p.bh;
                b_r <= p.br;
                start <= 1'b1;
                gap_left <= next_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: predict on each taken item, check each result strobe
    always @(posedge clk)
    begin : monitor
        pair_t seen;
        bit    want;
        item_taken <= start && !busy;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                seen.kind = kind_t'(opcode);
                seen.ax = a_x;
                seen.ay = a_y;
                seen.aw = a_w;
                seen.ah = a_h;
                seen.ar = a_r;
                seen.bx = b_x;
                seen.by = b_y;
                seen.bw = b_w;
                seen.bh = b_h;
                seen.br = b_r;
                expected_hits.push_back(pair_overlaps(seen));
            end
            if (done)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("unexpected result: hit %0b", hit);
                    mismatches++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (hit !== want)
                    begin
                        $error("hit: expected %0b, actual %0b", want, hit);
                        mismatches++;
                    end
                end
            end
            // watchdog
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        // circle with circle: zero radii, tangent, just inside, extremes
        pending_pairs.push_back(make_pair(KIND_CC, 0, 0, 5, 5, 0, 0, 0, 5, 5, 0));
        pending_pairs.push_back(make_pair(KIND_CC, 0, 0, 0, 0, 16, 48, 0, 0, 0, 32));
        pending_pairs.push_back(make_pair(KIND_CC, 0, 0, 0, 0, 16, 47, 0, 0, 0, 32));
        pending_pairs.push_back(make_pair(KIND_CC, -32768, -32768, 0, 0, 16383,
                                          32767, 32767, 0, 0, 16383));
        pending_pairs.push_back(make_pair(KIND_CC, 32767, 32767, 0, 0, 16383,
                                          32767, 32767, 0, 0, 16383));
        // circle with box: zero radius inside, widened edge, corners, extremes
        pending_pairs.push_back(make_pair(KIND_CB, 0, 0, 0, 0, 0, 0, 0, 32, 32, 0));
        pending_pairs.push_back(make_pair(KIND_CB, 24, 0, 0, 0, 8, 0, 0, 32, 32, 0));
        pending_pairs.push_back(make_pair(KIND_CB, 23, 0, 0, 0, 8, 0, 0, 32, 32, 0));
        pending_pairs.push_back(make_pair(KIND_CB, 0, -24, 0, 0, 8, 0, 0, 32, 32, 0));
        pending_pairs.push_back(make_pair(KIND_CB, 19, 20, 0, 0, 5, 0, 0, 32, 32, 0));
        pending_pairs.push_back(make_pair(KIND_CB, 19, 19, 0, 0, 5, 0, 0, 32, 32, 0));
        pending_pairs.push_back(make_pair(KIND_CB, 32767, 32767, 0, 0, 16383,
                                          -32768, -32768, 32767, 32767, 0));
        pending_pairs.push_back(make_pair(KIND_CB, 0, 0, 0, 0, 16383, 0, 0, 0, 0, 0));
        // box with box: touching edges, one apart, zero size, extremes
        pending_pairs.push_back(make_pair(KIND_BB, 0, 0, 32, 32, 0, 32, 0, 32, 32, 0));
        pending_pairs.push_back(make_pair(KIND_BB, 0, 0, 32, 32, 0, 33, 0, 32, 32, 0));
        pending_pairs.push_back(make_pair(KIND_BB, 7, -7, 0, 0, 0, 7, -7, 0, 0, 0));
        pending_pairs.push_back(make_pair(KIND_BB, 7, -7, 0, 0, 0, 7, -6, 0, 0, 0));
        pending_pairs.push_back(make_pair(KIND_BB, -32768, -32768, 32767, 32767, 0,
                                          32767, 32767, 32767, 32767, 0));
        pending_pairs.push_back(make_pair(KIND_BB, -32768, 32767, 32767, 32767, 0,
                                          -32768, 32767, 32767, 32767, 0));
        // reserved kind with overlapping shapes
        pending_pairs.push_back(make_pair(KIND_RSV, 0, 0, 32, 32, 16, 0, 0, 32, 32, 16));
        // every field all zeros, then all ones, for each kind
        for (int k = 0; k < 4; k++)
        begin
            pending_pairs.push_back(make_pair(kind_t'(k), 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
            pending_pairs.push_back(make_pair(kind_t'(k), -1, -1, 32767, 32767, 16383,
                                              -1, -1, 32767, 32767, 16383));
        end
        for (int n = 0; n < RANDOM_PAIRS; n++)
            pending_pairs.push_back(random_pair());

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while ((pending_pairs.size() != 0 || start || expected_hits.size() != 0) &&
               stall_cycles < STALL_LIMIT);

        if (stall_cycles >= STALL_LIMIT)
            $display("end of test: mismatches");
        else
        begin
            // let any stray strobe show up
            repeat (8) @(posedge clk);
            if (mismatches == 0)
                $display("end of test: clean");
            else
                $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/spo_pkg.sv
rtl/spo_prep.sv
rtl/spo_square.sv
rtl/spo_decide.sv
rtl/shape_pair_overlap_test.sv
rtl/spo_checker.sv
bench/tb_shape_pair_overlap_test.sv
